### design/door_lock_command_controller_assert.svh
// Assertion macros shared by the door lock command controller modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef DOOR_LOCK_COMMAND_CONTROLLER_ASSERT_SVH
`define DOOR_LOCK_COMMAND_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dlcc_pkg.sv
// Package for the door lock command controller: phases, command codes,
// register indexes and the config, result and push structs. No dependencies.
`default_nettype none

package dlcc_pkg;

  // Controller phases
  typedef enum logic [3:0] {
    PH_WAIT_MC1    = 4'd0,
    PH_WAIT_SAVE   = 4'd1,
    PH_SAVE_DIGIT  = 4'd2,
    PH_IDLE        = 4'd3,
    PH_WAIT_CHECK  = 4'd4,
    PH_CHECK_DIGIT = 4'd5,
    PH_UNLOCK      = 4'd6,
    PH_HOLD        = 4'd7,
    PH_RELOCK      = 4'd8,
    PH_ALARM       = 4'd9
  } phase_t;

  // Command and reply bytes
  localparam logic [7:0] C_NONE      = 8'h00;
  localparam logic [7:0] C_MC1_READY = 8'h10;
  localparam logic [7:0] C_READY     = 8'h20;
  localparam logic [7:0] C_CHANGE    = 8'hA0;
  localparam logic [7:0] C_SAVE      = 8'hA1;
  localparam logic [7:0] C_END_SAVE  = 8'hA2;
  localparam logic [7:0] C_CHECK     = 8'hA3;
  localparam logic [7:0] C_UNLOCK    = 8'hA4;
  localparam logic [7:0] C_BUZZER    = 8'hA5;
  localparam logic [7:0] C_PASSWORD  = 8'hA6;
  localparam logic [7:0] C_MATCH     = 8'hA7;
  localparam logic [7:0] C_NO_MATCH  = 8'hA8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UNLOCK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELOCK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY   = 3'd4;

  // Motor direction codes and duty ceiling
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;
  localparam logic [6:0] DUTY_MAX = 7'd100;

  // Output queue geometry
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = 2;
  localparam int unsigned CNT_W      = 3;

  typedef struct packed {
    logic [7:0] unlock_s;
    logic [7:0] hold_s;
    logic [7:0] relock_s;
    logic [7:0] alarm_s;
    logic [6:0] duty;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic [1:0] motor_dir;
    logic [6:0] motor_drive;
    logic       buzzer_active;
    logic       last_result;
  } res_t;

  // Push request from the core into the output queue
  typedef struct packed {
    logic push;
    logic two;
  } push_t;

endpackage

`default_nettype wire

### design/dlcc_cfg_regs.sv
// Configuration registers of the door lock command controller.
// Depends on dlcc_pkg for register indexes and the cfg_t struct.
`default_nettype none

module dlcc_cfg_regs
  import dlcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  output cfg_t                      cfg_o
);

  cfg_t cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unlock_s <= 8'd15;
      cfg_r.hold_s   <= 8'd3;
      cfg_r.relock_s <= 8'd15;
      cfg_r.alarm_s  <= 8'd60;
      cfg_r.duty     <= 7'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UNLOCK: cfg_r.unlock_s <= cfg_wdata;
        REG_HOLD:   cfg_r.hold_s   <= cfg_wdata;
        REG_RELOCK: cfg_r.relock_s <= cfg_wdata;
        REG_ALARM:  cfg_r.alarm_s  <= cfg_wdata;
        REG_DUTY:   cfg_r.duty     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

### design/dlcc_core.sv
// Input stage, phase machine, password store and result formation.
// Depends on dlcc_pkg and the assertion macro header.
`default_nettype none
`include "door_lock_command_controller_assert.svh"

module dlcc_core
  import dlcc_pkg::*;
#(
  parameter int PASSWORD_LENGTH = 5
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_rx_byte,
  input  wire cfg_t       cfg_i,
  input  wire logic       can_push_i,
  output push_t           push_o,
  output res_t            res0_o,
  output res_t            res1_o
);

  localparam int IDX_W = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
  localparam logic [3:0] PW_LEN = 4'(PASSWORD_LENGTH);

  // Input stage
  logic       stg_valid_r;
  logic       stg_mode_r;
  logic [7:0] stg_byte_r;
  logic       fire;

  // Controller state
  phase_t     phase_r, phase_nxt;
  logic [2:0] digit_r, digit_nxt;
  logic       mism_r, mism_nxt;
  logic [7:0] sec_r, sec_nxt;

  logic [7:0] saved_mem [PASSWORD_LENGTH];
  logic [7:0] saved_rd;
  logic       wr_en;

  logic [3:0] digit_inc;
  logic       digit_in_range;
  logic       more_digits;
  logic       mism_chk;
  logic [7:0] sec_inc;
  logic [7:0] limit;
  phase_t     tick_next;
  logic       counting;

  logic       r0_valid;
  logic [7:0] r0_byte;
  logic       r0_last;
  logic       two;
  logic [1:0] dir;
  logic [6:0] drive;
  logic [6:0] duty_sat;
  logic       buzz;

  assign fire     = stg_valid_r && can_push_i;
  assign in_ready = !stg_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_mode_r <= in_mode;
      stg_byte_r <= in_rx_byte;
    end
  end

  // Digit bookkeeping shared by save and check
  assign digit_inc      = {1'b0, digit_r} + 4'd1;
  assign digit_in_range = ({1'b0, digit_r} < PW_LEN);
  assign more_digits    = (digit_inc < PW_LEN);
  assign saved_rd       = saved_mem[digit_r[IDX_W-1:0]];
  assign mism_chk       = mism_r || !digit_in_range ||
                          (digit_in_range && (saved_rd != stg_byte_r));
  assign sec_inc        = sec_r + 8'd1;

  // Tick limit for the counted phases
  always_comb begin
    limit     = cfg_i.alarm_s;
    tick_next = PH_IDLE;
    counting  = 1'b1;
    unique case (phase_r)
      PH_UNLOCK: begin
        limit     = cfg_i.unlock_s;
        tick_next = PH_HOLD;
      end
      PH_HOLD: begin
        limit     = cfg_i.hold_s;
        tick_next = PH_RELOCK;
      end
      PH_RELOCK: begin
        limit     = cfg_i.relock_s;
        tick_next = PH_IDLE;
      end
      PH_ALARM: begin
        limit     = cfg_i.alarm_s;
        tick_next = PH_IDLE;
      end
      default: counting = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    digit_nxt = digit_r;
    mism_nxt  = mism_r;
    sec_nxt   = sec_r;
    wr_en     = 1'b0;
    if (stg_mode_r) begin
      if (counting) begin
        if (sec_inc == limit) begin
          sec_nxt   = 8'd0;
          phase_nxt = tick_next;
        end else begin
          sec_nxt = sec_inc;
        end
      end
    end else begin
      unique case (phase_r)
        PH_WAIT_MC1: begin
          if (stg_byte_r == C_MC1_READY) phase_nxt = PH_WAIT_SAVE;
        end
        PH_WAIT_SAVE: begin
          if (stg_byte_r == C_SAVE) begin
            phase_nxt = PH_SAVE_DIGIT;
            digit_nxt = 3'd0;
          end
        end
        PH_SAVE_DIGIT: begin
          wr_en = digit_in_range;
          if (more_digits) begin
            digit_nxt = digit_inc[2:0];
          end else begin
            digit_nxt = 3'd0;
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: begin
          if (stg_byte_r == C_PASSWORD) begin
            phase_nxt = PH_WAIT_CHECK;
          end else if (stg_byte_r == C_UNLOCK) begin
            phase_nxt = PH_UNLOCK;
            sec_nxt   = 8'd0;
          end else if (stg_byte_r == C_BUZZER) begin
            phase_nxt = PH_ALARM;
            sec_nxt   = 8'd0;
          end else if (stg_byte_r == C_CHANGE) begin
            phase_nxt = PH_WAIT_SAVE;
          end
        end
        PH_WAIT_CHECK: begin
          if (stg_byte_r == C_CHECK) begin
            phase_nxt = PH_CHECK_DIGIT;
            digit_nxt = 3'd0;
            mism_nxt  = 1'b0;
          end
        end
        PH_CHECK_DIGIT: begin
          mism_nxt = mism_chk;
          if (more_digits) begin
            digit_nxt = digit_inc[2:0];
          end else begin
            digit_nxt = 3'd0;
            phase_nxt = PH_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // Reply bytes for this item
  always_comb begin
    r0_valid = 1'b0;
    r0_byte  = C_NONE;
    r0_last  = 1'b1;
    two      = 1'b0;
    if (!stg_mode_r) begin
      unique case (phase_r) inside
        PH_WAIT_SAVE, PH_WAIT_CHECK: begin
          if ((phase_r == PH_WAIT_SAVE && stg_byte_r == C_SAVE) ||
              (phase_r == PH_WAIT_CHECK && stg_byte_r == C_CHECK)) begin
            r0_valid = 1'b1;
            r0_byte  = C_READY;
          end
        end
        PH_SAVE_DIGIT: begin
          r0_valid = 1'b1;
          r0_byte  = more_digits ? C_READY : C_END_SAVE;
        end
        PH_CHECK_DIGIT: begin
          r0_valid = 1'b1;
          r0_byte  = mism_chk ? C_NO_MATCH : C_MATCH;
          r0_last  = !more_digits;
          two      = more_digits;
        end
        default: ;
      endcase
    end
  end

  // Motor and buzzer status after this item
  assign duty_sat = (cfg_i.duty > DUTY_MAX) ? DUTY_MAX : cfg_i.duty;
  always_comb begin
    dir   = DIR_STOP;
    drive = 7'd0;
    if (phase_nxt == PH_UNLOCK) begin
      dir   = DIR_CW;
      drive = duty_sat;
    end else if (phase_nxt == PH_RELOCK) begin
      dir   = DIR_CCW;
      drive = duty_sat;
    end
  end
  assign buzz = (phase_nxt == PH_ALARM);

  assign res0_o = '{tx_valid: r0_valid, tx_byte: r0_byte, motor_dir: dir,
                    motor_drive: drive, buzzer_active: buzz, last_result: r0_last};
  assign res1_o = '{tx_valid: 1'b1, tx_byte: C_READY, motor_dir: dir,
                    motor_drive: drive, buzzer_active: buzz, last_result: 1'b1};
  assign push_o = '{push: fire, two: fire && two};

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_MC1;
      digit_r <= 3'd0;
      mism_r  <= 1'b0;
      sec_r   <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      digit_r <= digit_nxt;
      mism_r  <= mism_nxt;
      sec_r   <= sec_nxt;
    end
  end

  // Password store
  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      saved_mem[digit_r[IDX_W-1:0]] <= stg_byte_r;
    end
  end

  `DLCC_ASSERT_IMP(a_two_only_in_check, clk, rst_n, push_o.two, phase_r == PH_CHECK_DIGIT, "two replies outside digit check")
  `DLCC_ASSERT_IMP(a_digit_in_range, clk, rst_n, 1'b1, digit_in_range, "digit index past password length")
  `DLCC_ASSERT_NXT(a_stage_held, clk, rst_n, stg_valid_r && !fire, stg_valid_r && $stable(stg_byte_r), "staged item not held")

endmodule

`default_nettype wire

### design/dlcc_out_fifo.sv
// Result queue of the door lock command controller: takes one or two
// results per item, one out per ready cycle. Depends on dlcc_pkg.
`default_nettype none
`include "door_lock_command_controller_assert.svh"

module dlcc_out_fifo
  import dlcc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push_i,
  input  wire res_t  res0_i,
  input  wire res_t  res1_i,
  output logic       can_push_o,
  output logic       out_valid,
  input  wire logic  out_ready,
  output res_t       out_res_o
);

  localparam logic [CNT_W-1:0] DEPTH_C     = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] ROOM_TWO    = CNT_W'(FIFO_DEPTH - 2);
  localparam logic [CNT_W-1:0] ROOM_ONE    = CNT_W'(FIFO_DEPTH - 1);

  res_t              mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_push;
  logic              pop;

  assign pop        = (cnt_r != '0) && out_ready;
  assign out_valid  = (cnt_r != '0);
  assign out_res_o  = mem_r[rd_ptr_r];
  // Room for a worst-case item of two results
  assign can_push_o = (cnt_r <= ROOM_TWO) || ((cnt_r == ROOM_ONE) && pop);

  assign n_push     = push_i.push ? (push_i.two ? CNT_W'(2) : CNT_W'(1)) : '0;
  assign cnt_nxt    = cnt_r + n_push - CNT_W'(pop);
  assign wr_ptr_nxt = wr_ptr_r + n_push[PTR_W-1:0];
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push_i.push) begin
      mem_r[wr_ptr_r] <= res0_i;
      if (push_i.two) begin
        mem_r[wr_ptr_r + PTR_W'(1)] <= res1_i;
      end
    end
  end

  `DLCC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= DEPTH_C, "queue count above depth")
  `DLCC_ASSERT_IMP(a_push_has_room, clk, rst_n, push_i.push, can_push_o, "push without room")
  `DLCC_ASSERT_NXT(a_pop_drains, clk, rst_n, pop && !push_i.push, cnt_r == $past(cnt_r) - CNT_W'(1), "pop did not drain")

endmodule

`default_nettype wire

### design/door_lock_command_controller.sv
// Door lock command controller, top level.
// Depends on dlcc_pkg, dlcc_cfg_regs, dlcc_core and dlcc_out_fifo.
//
// Input channel (in_valid/in_ready): one item per handshake, either a
// received byte (in_mode 0, in_rx_byte) or a one-second tick (in_mode 1).
// Result channel (out_valid/out_ready): one or two results per item; the
// final one carries out_last_result. Each result holds the reply byte (when
// out_tx_valid) and the motor and buzzer status after the item.
// Config port: cfg_we writes cfg_wdata into register cfg_index (0 unlock,
// 1 hold, 2 relock, 3 alarm seconds, 4 motor duty); write only when idle.
// An item's results pass the input stage register, then the result queue.
// Throughput: one item per cycle while out_ready is high and each item
// yields one result; a digit check that yields two results is bounded by
// the single result port. The four-entry result queue takes an item only
// when it has room for two results, so a stalled receiver backs up into
// in_ready with nothing lost.
// Reset (synchronous, active low) waits for the partner ready byte, clears
// the counters and loads the default register values; the password store
// holds no value until a save sequence completes.
`default_nettype none

module door_lock_command_controller
  import dlcc_pkg::*;
#(
  parameter int PASSWORD_LENGTH = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_mode,
  input  wire logic [7:0]           in_rx_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_tx_valid,
  output logic [7:0]                out_tx_byte,
  output logic [1:0]                out_motor_dir,
  output logic [6:0]                out_motor_drive,
  output logic                      out_buzzer_active,
  output logic                      out_last_result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  cfg_t  cfg;
  push_t push;
  res_t  res0;
  res_t  res1;
  res_t  out_res;
  logic  can_push;

  dlcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  dlcc_core #(
    .PASSWORD_LENGTH (PASSWORD_LENGTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_mode    (in_mode),
    .in_rx_byte (in_rx_byte),
    .cfg_i      (cfg),
    .can_push_i (can_push),
    .push_o     (push),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  dlcc_out_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .res0_i     (res0),
    .res1_i     (res1),
    .can_push_o (can_push),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res_o  (out_res)
  );

  assign out_tx_valid      = out_res.tx_valid;
  assign out_tx_byte       = out_res.tx_byte;
  assign out_motor_dir     = out_res.motor_dir;
  assign out_motor_drive   = out_res.motor_drive;
  assign out_buzzer_active = out_res.buzzer_active;
  assign out_last_result   = out_res.last_result;

endmodule

`default_nettype wire
